// File: rtl/core/gspg_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the exponential table generator of the step pulse generator
package gspg_pkg;

  // input transaction: one microsecond tick or a start of move
  typedef struct packed {
    logic kind;
    logic direction;
  } in_item_t;

  // result transaction, one for every input transaction
  typedef struct packed {
    logic step_level;
    logic direction_level;
    logic busy_res;
    logic done_res;
  } out_item_t;

  localparam logic KindTick  = 1'b0;
  localparam logic KindStart = 1'b1;

  // configuration port
  localparam int unsigned CfgIndexW = 4;
  localparam int unsigned CfgDataW  = 24;

  localparam logic [CfgIndexW-1:0] CfgTotalSteps    = 4'd0;
  localparam logic [CfgIndexW-1:0] CfgRangeStart    = 4'd1;
  localparam logic [CfgIndexW-1:0] CfgStepIncrement = 4'd2;
  localparam logic [CfgIndexW-1:0] CfgCenter        = 4'd3;
  localparam logic [CfgIndexW-1:0] CfgInvTwoSigmaSq = 4'd4;
  localparam logic [CfgIndexW-1:0] CfgPeak          = 4'd5;
  localparam logic [CfgIndexW-1:0] CfgOffset        = 4'd6;
  localparam logic [CfgIndexW-1:0] CfgMultiplier    = 4'd7;

  // register values after reset
  localparam logic [15:0] RstTotalSteps    = 16'd267;
  localparam logic [20:0] RstRangeStart    = 21'h1C0000;
  localparam logic [19:0] RstStepIncrement = 20'd1966;
  localparam logic [20:0] RstCenter        = 21'd0;
  localparam logic [23:0] RstInvTwoSigmaSq = 24'd32768;
  localparam logic [19:0] RstPeak          = 20'hE3333;
  localparam logic [19:0] RstOffset        = 20'd117965;
  localparam logic [15:0] RstMultiplier    = 16'd500;

  // width of one exponential table entry (1.0 in q16 needs the top bit)
  localparam int unsigned ExpW = 17;

  // value of the calculation counter at which the half-period is loaded
  localparam logic [2:0] CalcLast = 3'd6;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HIGH,
    PH_LOW
  } phase_e;

  typedef enum logic {
    ST_WAIT,
    ST_CALC
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic start_move;
    logic dec_time;
    logic load_low;
    logic end_move;
    logic next_step;
    logic load_hp;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic time_expire;
    logic count_last;
    logic direction;
  } dp_status_t;

  // exp(-s) in q16 for s in q16, evaluated at elaboration only
  function automatic logic [ExpW-1:0] exp_q16(input longint s);
    longint y;
    longint t;
    longint sum;
    y   = s <<< 6;
    t   = y;
    sum = (longint'(1) <<< 30) - t;
    t   = ((t * y) >>> 30) / 2;
    sum = sum + t;
    t   = ((t * y) >>> 30) / 3;
    sum = sum - t;
    t   = ((t * y) >>> 30) / 4;
    sum = sum + t;
    t   = ((t * y) >>> 30) / 5;
    sum = sum - t;
    for (int k = 0; k < 8; k++) begin
      sum = (sum * sum + (longint'(1) <<< 29)) >>> 30;
    end
    return ExpW'((sum + 8192) >>> 14);
  endfunction

endpackage

// File: rtl/core/gspg_datapath.sv
`timescale 1ns / 1ps
// registers, move counters and the half-period arithmetic chain
module gspg_datapath
  import gspg_pkg::*;
#(
  parameter int unsigned EXP_TABLE_DEPTH = 256,
  parameter int unsigned DELAY_BITS      = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 start_dir_i,
  input  dp_cmd_t              cmd_i,
  output dp_status_t           status_o
);

  localparam int unsigned IdxW     = $clog2(EXP_TABLE_DEPTH);
  localparam int unsigned DepthW   = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int unsigned ProdW    = 20 + DepthW;
  localparam int unsigned RomBitsW = EXP_TABLE_DEPTH * ExpW;

  localparam logic [DepthW-1:0] DepthVal = DepthW'(EXP_TABLE_DEPTH);
  localparam logic [24:0]       MaxDelay = 25'((1 << DELAY_BITS) - 1);
  localparam logic [24:0]       PosMax   = 25'((1 << 23) - 1);

  function automatic logic [RomBitsW-1:0] build_rom();
    logic [RomBitsW-1:0] bits;
    longint s;
    bits = '0;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      s = (longint'(i) <<< 20) / EXP_TABLE_DEPTH;
      bits[i*ExpW +: ExpW] = exp_q16(s);
    end
    return bits;
  endfunction

  localparam logic [RomBitsW-1:0] ExpRom = build_rom();

  // configuration registers
  logic [15:0] total_steps_q;
  logic [20:0] range_start_q;
  logic [19:0] step_inc_q;
  logic [20:0] center_q;
  logic [23:0] inv_q;
  logic [19:0] peak_q;
  logic [19:0] offset_q;
  logic [15:0] mult_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_steps_q <= RstTotalSteps;
      range_start_q <= RstRangeStart;
      step_inc_q    <= RstStepIncrement;
      center_q      <= RstCenter;
      inv_q         <= RstInvTwoSigmaSq;
      peak_q        <= RstPeak;
      offset_q      <= RstOffset;
      mult_q        <= RstMultiplier;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgTotalSteps:    total_steps_q <= cfg_data_i[15:0];
        CfgRangeStart:    range_start_q <= cfg_data_i[20:0];
        CfgStepIncrement: step_inc_q    <= cfg_data_i[19:0];
        CfgCenter:        center_q      <= cfg_data_i[20:0];
        CfgInvTwoSigmaSq: inv_q         <= cfg_data_i[23:0];
        CfgPeak:          peak_q        <= cfg_data_i[19:0];
        CfgOffset:        offset_q      <= cfg_data_i[19:0];
        CfgMultiplier:    mult_q        <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // move state
  logic [15:0]           count_q, count_d;
  logic [23:0]           pos_q, pos_d;
  logic [DELAY_BITS-1:0] time_q, time_d;
  logic [DELAY_BITS-1:0] hp_q, hp_d;
  logic                  dir_q, dir_d;

  // arithmetic chain, one register per step
  logic [23:0]        ad_q, ad_d;
  logic [31:0]        u_q, u_d;
  logic [39:0]        t_q, t_d;
  logic [ExpW-1:0]    e_q, e_d;
  logic signed [22:0] c_q, c_d;
  logic signed [23:0] us_q, us_d;

  logic signed [24:0]  diff;
  logic [47:0]         sq_prod;
  logic [55:0]         t_prod;
  logic [ProdW-1:0]    idx_prod;
  logic [IdxW-1:0]     rom_idx;
  logic signed [37:0]  pe_prod;
  logic signed [37:0]  pe_round;
  logic signed [39:0]  us_prod;
  logic signed [24:0]  pos_sum;
  logic [15:0]         count_next;
  logic [DELAY_BITS-1:0] hp_clamped;

  always_comb begin
    diff    = $signed({pos_q[23], pos_q}) - $signed({{4{center_q[20]}}, center_q});
    ad_d    = diff[24] ? 24'(-diff) : diff[23:0];
    sq_prod = 48'(ad_q) * 48'(ad_q);
    u_d     = sq_prod[47:16];
    t_prod  = 56'(u_q) * 56'(inv_q);
    t_d     = t_prod[55:16];
    // t below 16.0 indexes the table, beyond that exp is taken as zero
    idx_prod = ProdW'(t_q[19:0]) * ProdW'(DepthVal);
    rom_idx  = idx_prod[20 +: IdxW];
    e_d      = (t_q[39:20] == 20'd0) ? ExpRom[rom_idx * ExpW +: ExpW] : '0;
    pe_prod  = 38'($signed(peak_q)) * 38'($signed({1'b0, e_q}));
    pe_round = pe_prod + 38'sd32768;
    c_d      = $signed({pe_round[37], pe_round[37:16]})
             + $signed({{3{offset_q[19]}}, offset_q});
    us_prod  = 40'(c_q) * 40'($signed({1'b0, mult_q}));
    us_d     = us_prod[39:16];
  end

  always_ff @(posedge clk_i) begin
    ad_q <= ad_d;
    u_q  <= u_d;
    t_q  <= t_d;
    e_q  <= e_d;
    c_q  <= c_d;
    us_q <= us_d;
  end

  always_comb begin
    if ($signed({us_q[23], us_q}) < 25'sd1) begin
      hp_clamped = DELAY_BITS'(1);
    end else if ($signed({us_q[23], us_q}) > $signed(MaxDelay)) begin
      hp_clamped = MaxDelay[DELAY_BITS-1:0];
    end else begin
      hp_clamped = us_q[DELAY_BITS-1:0];
    end
  end

  assign count_next = count_q + 16'd1;
  assign pos_sum    = $signed({pos_q[23], pos_q}) + $signed({5'd0, step_inc_q});

  always_comb begin
    count_d = count_q;
    pos_d   = pos_q;
    time_d  = time_q;
    hp_d    = hp_q;
    dir_d   = dir_q;
    if (cmd_i.start_move) begin
      dir_d   = start_dir_i;
      count_d = '0;
      pos_d   = {{3{range_start_q[20]}}, range_start_q};
    end
    if (cmd_i.dec_time) begin
      time_d = time_q - DELAY_BITS'(1);
    end
    if (cmd_i.load_low) begin
      time_d = hp_q;
    end
    if (cmd_i.end_move) begin
      count_d = count_next;
      time_d  = '0;
    end
    if (cmd_i.next_step) begin
      count_d = count_next;
      // position saturates at the top of its range
      pos_d   = (pos_sum > $signed(PosMax)) ? PosMax[23:0] : pos_sum[23:0];
    end
    if (cmd_i.load_hp) begin
      hp_d   = hp_clamped;
      time_d = hp_clamped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pos_q   <= '0;
      time_q  <= '0;
      hp_q    <= '0;
      dir_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      pos_q   <= pos_d;
      time_q  <= time_d;
      hp_q    <= hp_d;
      dir_q   <= dir_d;
    end
  end

  assign status_o.time_expire = (time_q <= DELAY_BITS'(1));
  assign status_o.count_last  = (count_next >= total_steps_q);
  assign status_o.direction   = dir_q;

endmodule

// File: rtl/core/gspg_ctrl.sv
`timescale 1ns / 1ps
// controller: pulse phase, calculation sequencing and the result register
module gspg_ctrl
  import gspg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_data_o,
  output dp_cmd_t    cmd_o,
  input  dp_status_t status_i
);

  ctrl_state_e state_q, state_d;
  phase_e      phase_q, phase_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_data_q, out_data_d;

  logic accept;
  logic active;
  logic calc_done;
  logic ev_start;
  logic ev_dec;
  logic ev_to_low;
  logic ev_end;
  logic ev_next;
  logic out_write;
  logic done_flag;

  assign in_ready_o = (state_q == ST_WAIT) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign active     = (phase_q != PH_IDLE);
  assign calc_done  = (state_q == ST_CALC) && (cnt_q == CalcLast);

  // classify the accepted transaction
  always_comb begin
    ev_start  = 1'b0;
    ev_dec    = 1'b0;
    ev_to_low = 1'b0;
    ev_end    = 1'b0;
    ev_next   = 1'b0;
    if (accept && active && (in_data_i.kind == KindTick)) begin
      if (!status_i.time_expire) begin
        ev_dec = 1'b1;
      end else if (phase_q == PH_HIGH) begin
        ev_to_low = 1'b1;
      end else if (status_i.count_last) begin
        ev_end = 1'b1;
      end else begin
        ev_next = 1'b1;
      end
    end
    if (accept && !active && (in_data_i.kind == KindStart)) begin
      ev_start = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_WAIT: begin
        cnt_d = '0;
        if (ev_start || ev_next) begin
          phase_d = PH_HIGH;
          state_d = ST_CALC;
        end else if (ev_to_low) begin
          phase_d = PH_LOW;
        end else if (ev_end) begin
          phase_d = PH_IDLE;
        end
      end
      ST_CALC: begin
        cnt_d = cnt_q + 3'd1;
        if (calc_done) begin
          state_d = ST_WAIT;
        end
      end
      default: begin
        state_d = ST_WAIT;
      end
    endcase
  end

  // commands and result
  always_comb begin
    cmd_o            = '0;
    cmd_o.start_move = ev_start;
    cmd_o.dec_time   = ev_dec;
    cmd_o.load_low   = ev_to_low;
    cmd_o.end_move   = ev_end;
    cmd_o.next_step  = ev_next;
    cmd_o.load_hp    = calc_done;
    // moves that need a new half-period report once it is loaded
    out_write = (accept && !ev_start && !ev_next) || calc_done;
    done_flag = ev_end;
    out_data_d.step_level      = (phase_d == PH_HIGH);
    out_data_d.direction_level = status_i.direction;
    out_data_d.busy_res        = (phase_d != PH_IDLE);
    out_data_d.done_res        = done_flag;
    if (out_write) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_WAIT;
      phase_q     <= PH_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_write) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: rtl/core/gaussian_step_pulse_generator.sv
`timescale 1ns / 1ps
// top level of the gaussian step pulse generator
//
// stepper pulse generator whose half-period follows an inverted gaussian
// curve of the step position. a start transaction latches the direction and
// begins a move of total_steps pulses; every tick transaction counts one
// microsecond, the step line staying high for one half-period and low for
// one. each input transaction yields exactly one result transaction showing
// the state after it, done_res marking the tick that ends the last pulse.
// a start while a move runs is ignored. timing: the result of a plain tick
// is registered at the same edge that takes it. a start, and a tick
// that ends a low half and begins the next pulse, runs the half-period
// through the arithmetic chain (distance, square, sigma scaling, exp table
// read, peak and offset, multiplier, clamp), one register per step, so that
// transaction's result is registered when the half-period is loaded, and
// no further transaction is taken before the chain is done. a new one is
// taken when the chain is free and the result register is empty or being
// read in that cycle. configuration writes are always taken; they are meant
// for quiet periods between moves, and each half-period uses the register
// values current when it is computed. the exp table is built at elaboration
// with EXP_TABLE_DEPTH entries covering exponents 0 to 16; DELAY_BITS sets
// the saturation of the half-period in microseconds
module gaussian_step_pulse_generator
  import gspg_pkg::*;
#(
  parameter int unsigned EXP_TABLE_DEPTH = 256,
  parameter int unsigned DELAY_BITS      = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input transactions
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  // result transactions
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o,
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // register writes are always taken and complete at the edge that takes them
  assign cfg_ready_o = 1'b1;

  // phase tracking, sequencing of the arithmetic chain, result register
  gspg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // configuration, counters and the half-period arithmetic
  gspg_datapath #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH),
    .DELAY_BITS      (DELAY_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .start_dir_i (in_data_i.direction),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
